>>> hdl/weighted_average_audio_mixer_macros.svh
// Assertion macros for the audio mixer.
// In synthesis both macros expand to nothing.
`ifndef WEIGHTED_AVERAGE_AUDIO_MIXER_MACROS_SVH
`define WEIGHTED_AVERAGE_AUDIO_MIXER_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define WAVM_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wavm assertion failed");

// next-cycle implication
`define WAVM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wavm assertion failed");

`else

`define WAVM_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define WAVM_ASSERT_NEXT(name, clk, rst_n, ante, cons)

`endif

`endif

>>> hdl/wavm_pkg.sv
package wavm_pkg;

	localparam int NUM_TRACKS = 4;
	localparam int SAMPLE_W   = 16;
	localparam int VOL_W      = 8;
	localparam logic [VOL_W-1:0] VOL_RESET = 8'd16;

	localparam int TRK_W      = (NUM_TRACKS > 1) ? $clog2(NUM_TRACKS) : 0;
	localparam int PROD_W     = SAMPLE_W + VOL_W;      // signed sample * unsigned volume
	localparam int SUM_W      = PROD_W + TRK_W;        // signed sum of products
	localparam int WGT_W      = VOL_W + TRK_W;         // unsigned sum of volumes
	localparam int MAG_W      = SUM_W - 1;             // |sum| fits one bit less
	localparam int WGT_MAX    = NUM_TRACKS * ((1 << VOL_W) - 1);

	localparam int CFG_IDX_W  = TRK_W + 1;

	// restoring divider: DIV_STEPS quotient bits per pipeline stage
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
	localparam int NUM_W      = DIV_STAGES * DIV_STEPS;

	localparam int TDATA_W    = NUM_TRACKS * SAMPLE_W;

	// largest quotient magnitude a weighted average can reach
	localparam logic [NUM_W-1:0] QUO_MAX = NUM_W'(1 << (SAMPLE_W - 1));

	typedef struct packed {
		logic [NUM_W-1:0] num;   // dividend shifting out, quotient shifting in
		logic [WGT_W-1:0] rem;   // partial remainder
		logic [WGT_W-1:0] den;   // divisor (sum of active volumes)
		logic             neg;   // weighted sum was negative
		logic             zero;  // divisor is zero, result is silence
	} div_item_t;

endpackage

>>> hdl/wavm_div.sv
module wavm_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  wavm_pkg::div_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output wavm_pkg::div_item_t out_item
);
	import wavm_pkg::*;

	// DIV_STEPS restoring steps on one item
	function automatic div_item_t div_stage(input div_item_t x);
		div_item_t        y;
		logic [WGT_W:0]   trial;
		y = x;
		for (int i = 0; i < DIV_STEPS; i++) begin
			trial = {y.rem, y.num[NUM_W-1]};
			if (trial >= {1'b0, y.den}) begin
				y.rem = WGT_W'(trial - {1'b0, y.den});
				y.num = {y.num[NUM_W-2:0], 1'b1};
			end else begin
				y.rem = trial[WGT_W-1:0];
				y.num = {y.num[NUM_W-2:0], 1'b0};
			end
		end
		return y;
	endfunction

	logic [DIV_STAGES-1:0] valid_s;
	div_item_t             item_s [DIV_STAGES];
	wire  [DIV_STAGES:0]   rdy;

	assign rdy[DIV_STAGES] = out_ready;
	assign in_ready        = rdy[0];

	genvar g;
	generate
		for (g = 0; g < DIV_STAGES; g++) begin : g_stage
			logic      vin;
			div_item_t iin;

			if (g == 0) begin : g_first
				assign vin = in_valid;
				assign iin = in_item;
			end else begin : g_rest
				assign vin = valid_s[g-1];
				assign iin = item_s[g-1];
			end

			assign rdy[g] = !valid_s[g] || rdy[g+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s[g] <= 1'b0;
				end else if (rdy[g]) begin
					valid_s[g] <= vin;
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[g] && vin) begin
					item_s[g] <= div_stage(iin);
				end
			end
		end
	endgenerate

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_item  = item_s[DIV_STAGES-1];

endmodule

>>> hdl/weighted_average_audio_mixer.sv
// Weighted-average audio mixer. Each input transaction carries one signed 16-bit
// sample per track (s_tdata, track 0 in the lowest bits) and an active mask
// (s_tuser, bit k for track k). The output transaction carries the sum of
// sample * volume over active tracks, divided by the sum of their volumes and
// truncated toward zero; silence (0) when that weight is zero. Volumes are
// 8-bit unsigned weights written through cfg_we / cfg_index / cfg_data (index k
// is track k, other indexes are ignored; reset value 16); write them only while
// no transaction is in flight. One transaction is taken per clock while m_tready
// does not stall the pipeline. From input to output register there are one
// multiply stage, one sum stage, one magnitude stage, a restoring divider that
// resolves four quotient bits per stage, and the output register. Every stage
// has its own valid bit and ready term, so bubbles close up and a stall on
// m_tready backs up stage by stage without losing or repeating a transaction.

`include "weighted_average_audio_mixer_macros.svh"

module weighted_average_audio_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [wavm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [wavm_pkg::VOL_W-1:0]        cfg_data,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [wavm_pkg::TDATA_W-1:0]      s_tdata,   // sample_track0 .. sample_track(N-1)
	input  logic [wavm_pkg::NUM_TRACKS-1:0]   s_tuser,   // active_mask
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [wavm_pkg::SAMPLE_W-1:0]     m_tdata    // mixed_sample
);
	import wavm_pkg::*;

	// volume registers
	logic [VOL_W-1:0] vol_q [NUM_TRACKS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_TRACKS; k++) begin
				vol_q[k] <= VOL_RESET;
			end
		end else if (cfg_we) begin
			for (int k = 0; k < NUM_TRACKS; k++) begin
				if (cfg_index == CFG_IDX_W'(k)) begin
					vol_q[k] <= cfg_data;
				end
			end
		end
	end

	// ready chain, back to front
	logic rdy_s1, rdy_s2, rdy_s3, rdy_out;
	logic valid_s1, valid_s2, valid_s3;
	logic div_in_ready, div_out_valid;
	div_item_t div_out_item;

	logic out_valid_q;
	logic [SAMPLE_W-1:0] mixed_q;

	assign rdy_out  = !out_valid_q || m_tready;
	assign rdy_s3   = !valid_s3 || div_in_ready;
	assign rdy_s2   = !valid_s2 || rdy_s3;
	assign rdy_s1   = !valid_s1 || rdy_s2;
	assign s_tready = rdy_s1;

	// stage 1: per-track products, masked by the active bits
	logic signed [PROD_W-1:0] prod_c  [NUM_TRACKS];
	logic        [VOL_W-1:0]  wgt_c   [NUM_TRACKS];
	logic signed [PROD_W-1:0] prod_s1 [NUM_TRACKS];
	logic        [VOL_W-1:0]  wgt_s1  [NUM_TRACKS];

	always_comb begin
		logic signed [SAMPLE_W-1:0] smp;
		logic signed [VOL_W:0]      vext;
		logic signed [PROD_W:0]     full;
		for (int k = 0; k < NUM_TRACKS; k++) begin
			smp  = s_tdata[k*SAMPLE_W +: SAMPLE_W];
			vext = {1'b0, vol_q[k]};
			full = smp * vext;
			if (s_tuser[k]) begin
				prod_c[k] = full[PROD_W-1:0];
				wgt_c[k]  = vol_q[k];
			end else begin
				prod_c[k] = '0;
				wgt_c[k]  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rdy_s1) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && s_tvalid) begin
			prod_s1 <= prod_c;
			wgt_s1  <= wgt_c;
		end
	end

	// stage 2: weighted sum and total weight
	logic signed [SUM_W-1:0] sum_c, sum_s2;
	logic        [WGT_W-1:0] wsum_c, wsum_s2;

	always_comb begin
		sum_c  = '0;
		wsum_c = '0;
		for (int k = 0; k < NUM_TRACKS; k++) begin
			sum_c  = sum_c + SUM_W'(prod_s1[k]);
			wsum_c = wsum_c + WGT_W'(wgt_s1[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			sum_s2  <= sum_c;
			wsum_s2 <= wsum_c;
		end
	end

	// stage 3: sign and magnitude for the unsigned divider
	div_item_t item_c, item_s3;
	logic [SUM_W-1:0] abs_c;

	always_comb begin
		abs_c        = sum_s2[SUM_W-1] ? SUM_W'(-sum_s2) : SUM_W'(sum_s2);
		item_c.num   = NUM_W'(abs_c[MAG_W-1:0]);
		item_c.rem   = '0;
		item_c.den   = wsum_s2;
		item_c.neg   = sum_s2[SUM_W-1];
		item_c.zero  = (wsum_s2 == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			item_s3 <= item_c;
		end
	end

	// pipelined restoring divider
	wavm_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_s3),
		.in_ready  (div_in_ready),
		.in_item   (item_s3),
		.out_valid (div_out_valid),
		.out_ready (rdy_out),
		.out_item  (div_out_item)
	);

	// output register: restore sign, force silence on zero weight
	logic [SAMPLE_W-1:0] quo_c, mixed_c;

	always_comb begin
		quo_c = div_out_item.num[SAMPLE_W-1:0];
		if (div_out_item.zero) begin
			mixed_c = '0;
		end else if (div_out_item.neg) begin
			mixed_c = SAMPLE_W'(-quo_c);
		end else begin
			mixed_c = quo_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= div_out_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out && div_out_valid) begin
			mixed_q <= mixed_c;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = mixed_q;

	// input backs up only when every stage is full and the sink is stalling
	`WAVM_ASSERT_IMPL(a_backpressure, clk, arst_n, !s_tready, m_tvalid && !m_tready && valid_s1)
	// total weight never exceeds every track at full volume
	`WAVM_ASSERT_IMPL(a_wsum_range, clk, arst_n, valid_s2, wsum_s2 <= WGT_W'(WGT_MAX))
	// a nonzero-weight quotient always fits the sample range
	`WAVM_ASSERT_IMPL(a_quo_range, clk, arst_n, div_out_valid && !div_out_item.zero,
		div_out_item.num <= QUO_MAX)
	// divider entry holds while it is refused
	`WAVM_ASSERT_NEXT(a_s3_hold, clk, arst_n, valid_s3 && !div_in_ready,
		valid_s3 && $stable(item_s3))

endmodule
